// File: hw/rtl/epsc_pkg.sv
// Shared constants for the encoder pulse count and speed block.
`timescale 1ns / 1ps
package epsc_pkg;

  // Field widths
  localparam int unsigned TS_W    = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SPEED_W = 34;
  localparam int unsigned TPR_W   = 16;
  localparam int unsigned PROD_W  = TS_W + TPR_W;

  // Speed numerator: 60e6 us per minute, scaled by 256 for Q8
  localparam logic [SPEED_W-1:0] SPEED_NUM_Q8 = 34'd15360000000;

  // Divider step count, one quotient bit per step
  localparam int unsigned DIV_STEPS = SPEED_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic CFG_TPR = 1'b0;
  localparam logic CFG_FWD = 1'b1;

  // Register reset values
  localparam logic [TPR_W-1:0] TPR_RESET = 16'd45;
  localparam logic             FWD_RESET = 1'b1;

endpackage

// File: hw/rtl/epsc_div.sv
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module epsc_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [epsc_pkg::SPEED_W-1:0]         dividend,
  input  logic [epsc_pkg::PROD_W-1:0]          divisor,
  output logic                                 done,
  output logic [epsc_pkg::SPEED_W-1:0]         quotient
);

  logic                               busy;
  logic [epsc_pkg::DIV_CNT_W-1:0]     cnt;
  logic [epsc_pkg::PROD_W-1:0]        rem;
  logic [epsc_pkg::SPEED_W-1:0]       quo;
  logic [epsc_pkg::PROD_W:0]          trial;
  logic [epsc_pkg::PROD_W:0]          diff;
  logic                               take;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[epsc_pkg::SPEED_W-1]};
    diff  = trial - {1'b0, divisor};
    take  = (trial >= {1'b0, divisor});
  end

  assign quotient = quo;

  // Sequence the steps; a zero divisor yields all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= epsc_pkg::DIV_CNT_W'(epsc_pkg::DIV_STEPS - 1);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= take ? diff[epsc_pkg::PROD_W-1:0] : trial[epsc_pkg::PROD_W-1:0];
        quo <= {quo[epsc_pkg::SPEED_W-2:0], take};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - epsc_pkg::DIV_CNT_W'(1);
        end
      end
    end
  end

endmodule

// File: hw/rtl/encoder_pulse_count_and_speed.sv
// Encoder pulse counter with period-based speed, top level.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in      | sink      | in_valid/in_stall  | edge_level, direction_level, timestamp_us
//   out     | source    | out_valid/out_stall| position_count, speed_rpm_q8, speed_updated
//   cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A falling edge, or the first rising edge, goes to S_DONE and shows its result once the
// output register is free. A rising edge with a speed update steps through the 32x16 product,
// the divider launch, 34 one-bit divider steps, taking the quotient, and loading the output.
// Reset clears count, rise flag, held speed and loads the register defaults.
// in_stall stays high while an edge is in work; a stalled result holds in the output
// register, and the next edge may be accepted meanwhile.
`timescale 1ns / 1ps
module encoder_pulse_count_and_speed (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                edge_level,
  input  logic                                direction_level,
  input  logic [epsc_pkg::TS_W-1:0]           timestamp_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [epsc_pkg::COUNT_W-1:0] position_count,
  output logic [epsc_pkg::SPEED_W-1:0]        speed_rpm_q8,
  output logic                                speed_updated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [epsc_pkg::TPR_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  state_t                         state;
  logic [epsc_pkg::TPR_W-1:0]     tpr;
  logic                           fwd;
  logic [epsc_pkg::COUNT_W-1:0]   pulse_count;
  logic [epsc_pkg::TS_W-1:0]      last_rise_time;
  logic                           rise_seen;
  logic [epsc_pkg::SPEED_W-1:0]   speed_value;
  logic [epsc_pkg::TS_W-1:0]      period;
  logic [epsc_pkg::PROD_W-1:0]    product;
  logic                           updated;
  logic                           div_start;
  logic                           div_done;
  logic [epsc_pkg::SPEED_W-1:0]   div_quo;
  logic                           in_fire;
  logic                           out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;
  assign div_start = (state == S_START);

  // Divider for the speed quotient
  epsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (epsc_pkg::SPEED_NUM_Q8),
    .divisor  (product),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tpr <= epsc_pkg::TPR_RESET;
      fwd <= epsc_pkg::FWD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        epsc_pkg::CFG_TPR: tpr <= cfg_data;
        epsc_pkg::CFG_FWD: fwd <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pulse_count    <= '0;
      last_rise_time <= '0;
      rise_seen      <= 1'b0;
      speed_value    <= '0;
      updated        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // Drop the result once it is taken, unless a new one loads now
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            pulse_count <= (direction_level == fwd)
                           ? pulse_count + epsc_pkg::COUNT_W'(1)
                           : pulse_count - epsc_pkg::COUNT_W'(1);
            if (edge_level) begin
              last_rise_time <= timestamp_us;
              rise_seen      <= 1'b1;
            end
            if (edge_level && rise_seen) begin
              period  <= timestamp_us - last_rise_time;
              updated <= 1'b1;
              state   <= S_MUL;
            end else begin
              updated <= 1'b0;
              state   <= S_DONE;
            end
          end
        end
        S_MUL: begin
          product <= epsc_pkg::PROD_W'(period) * epsc_pkg::PROD_W'(tpr);
          state   <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            speed_value <= div_quo;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          // Load the output register when it is free
          if (out_free) begin
            position_count <= pulse_count;
            speed_rpm_q8   <= speed_value;
            speed_updated  <= updated;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
